[sv/word_fed_crc32_engine_unit_defines.svh]
// Assertion macros for the word-fed CRC-32 engine.
`ifndef WORD_FED_CRC32_ENGINE_UNIT_DEFINES_SVH
`define WORD_FED_CRC32_ENGINE_UNIT_DEFINES_SVH

`ifndef SYNTH

`define WFC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

`define WFC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define WFC_ASSERT_IMPL(label, clk, rst_n, ante, cons)

`define WFC_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

[sv/wfcrc_pkg.sv]
// Package: CRC-32 constants, running state type and word fold function.
`default_nettype none

package wfcrc_pkg;

    localparam int unsigned C_WORD_BITS  = 32;
    localparam int unsigned C_WORD_BYTES = 4;
    localparam int unsigned C_HELD_BITS  = C_WORD_BITS - 8;

    localparam logic [31:0] C_POLY     = 32'h04C1_1DB7;
    localparam logic [31:0] C_CRC_INIT = 32'hFFFF_FFFF;
    localparam logic [31:0] C_CRC_MSB  = 32'h8000_0000;
    localparam logic [7:0]  C_PAD_BYTE = 8'hFF;
    localparam logic [1:0]  C_LAST_POS = 2'(C_WORD_BYTES - 1);

    typedef struct packed {
        logic [31:0]            crc;
        logic [C_HELD_BITS-1:0] partial;
        logic [1:0]             pos;
    } t_crc_state;

    typedef logic [C_WORD_BITS-1:0][31:0] t_fold_cols;

    // Bit-serial fold, used only to build the constant matrix.
    function automatic logic [31:0] shift_word(input logic [31:0] x);
        logic [31:0] v;
        v = x;
        for (int i = 0; i < C_WORD_BITS; i++) begin
            if ((v & C_CRC_MSB) != 32'd0) begin
                v = (v << 1) ^ C_POLY;
            end else begin
                v = v << 1;
            end
        end
        return v;
    endfunction

    function automatic t_fold_cols build_cols();
        t_fold_cols c;
        for (int i = 0; i < C_WORD_BITS; i++) begin
            c[i] = shift_word(32'd1 << i);
        end
        return c;
    endfunction

    localparam t_fold_cols C_FOLD_COLS = build_cols();

    // XOR word into CRC and advance 32 bit steps (linear, flat XOR tree).
    function automatic logic [31:0] fold_word(input logic [31:0] crc,
                                              input logic [31:0] word);
        logic [31:0] v;
        logic [31:0] res;
        v   = crc ^ word;
        res = '0;
        for (int i = 0; i < C_WORD_BITS; i++) begin
            res = res ^ ({32{v[i]}} & C_FOLD_COLS[i]);
        end
        return res;
    endfunction

endpackage

`default_nettype wire

[sv/wfcrc_datapath.sv]
// Byte packing, pad and fold logic: next running state and finished CRC.
`default_nettype none

module wfcrc_datapath (
    input  wire  wfcrc_pkg::t_crc_state i_state,
    input  wire  logic [7:0]            i_data_byte,
    input  wire  logic                  i_byte_valid,
    input  wire  logic                  i_last,
    output       wfcrc_pkg::t_crc_state o_next_state,
    output       logic [31:0]           o_crc
);
    import wfcrc_pkg::*;

    logic [31:0] held;
    logic [31:0] word;
    logic        full;
    logic        do_fold;
    logic [31:0] crc_out;
    logic [C_HELD_BITS-1:0] partial_upd;

    always_comb begin
        held = {8'h00, i_state.partial};
        full = i_byte_valid && (i_state.pos == C_LAST_POS);
        for (int k = 0; k < C_WORD_BYTES; k++) begin
            if (2'(k) < i_state.pos) begin
                word[k*8 +: 8] = held[k*8 +: 8];
            end else if (i_byte_valid && (2'(k) == i_state.pos)) begin
                word[k*8 +: 8] = i_data_byte;
            end else begin
                word[k*8 +: 8] = C_PAD_BYTE;
            end
        end
        do_fold = full || (i_last && (i_byte_valid || (i_state.pos != 2'd0)));
        crc_out = do_fold ? fold_word(i_state.crc, word) : i_state.crc;

        partial_upd = i_state.partial;
        for (int k = 0; k < C_WORD_BYTES - 1; k++) begin
            if (i_byte_valid && (2'(k) == i_state.pos)) begin
                partial_upd[k*8 +: 8] = i_data_byte;
            end
        end

        o_next_state = i_state;
        if (i_last) begin
            o_next_state.crc     = C_CRC_INIT;
            o_next_state.partial = '0;
            o_next_state.pos     = 2'd0;
        end else if (full) begin
            o_next_state.crc     = crc_out;
            o_next_state.partial = '0;
            o_next_state.pos     = 2'd0;
        end else if (i_byte_valid) begin
            o_next_state.partial = partial_upd;
            o_next_state.pos     = i_state.pos + 2'd1;
        end
        o_crc = crc_out;
    end

endmodule

`default_nettype wire

[sv/word_fed_crc32_engine_unit.sv]
// Top level: word-fed CRC-32 engine with input and result registers.
`default_nettype none

// One request per cycle: a byte (byte_valid), an optional end-of-image mark
// (last), or both. Bytes pack LSB first into 32-bit words; each full word is
// folded into the CRC (poly 04C11DB7, init all ones, MSB first, no reflection,
// no final XOR). On last, a partial word is padded with FF bytes and folded,
// the CRC is presented on o_crc_value and the running state returns to init;
// a bare end mark on an empty image gives FFFFFFFF. Throughput is one request
// per cycle; a taken request lands in the input register, then the
// combinational fold writes the result register, which presents the result.
// Only a last request waits on a stalled result register.

module word_fed_crc32_engine_unit (
    input  wire  logic        i_clk,
    input  wire  logic        i_rst_n,
    input  wire  logic        i_in_valid,
    output       logic        o_in_stall,
    input  wire  logic [7:0]  i_data_byte,
    input  wire  logic        i_byte_valid,
    input  wire  logic        i_last,
    output       logic        o_out_valid,
    input  wire  logic        i_out_stall,
    output       logic [31:0] o_crc_value
);
    import wfcrc_pkg::*;

`include "word_fed_crc32_engine_unit_defines.svh"

    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_bv;
    logic        r_in_last;
    t_crc_state  r_state;
    logic        r_out_valid;
    logic [31:0] r_out_crc;

    t_crc_state  n_state;
    logic [31:0] w_crc;
    logic        out_free;
    logic        proc;
    logic        in_take;

    wfcrc_datapath u_datapath (
        .i_state      (r_state),
        .i_data_byte  (r_in_byte),
        .i_byte_valid (r_in_bv),
        .i_last       (r_in_last),
        .o_next_state (n_state),
        .o_crc        (w_crc)
    );

    always_comb begin
        out_free   = !r_out_valid || !i_out_stall;
        proc       = r_in_valid && (!r_in_last || out_free);
        o_in_stall = r_in_valid && !proc;
        in_take    = i_in_valid && !o_in_stall;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_state.crc     <= C_CRC_INIT;
            r_state.partial <= '0;
            r_state.pos     <= 2'd0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (proc) begin
                r_in_valid <= 1'b0;
            end
            if (proc) begin
                r_state <= n_state;
            end
            if (proc && r_in_last) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_byte <= i_data_byte;
            r_in_bv   <= i_byte_valid;
            r_in_last <= i_last;
        end
        if (proc && r_in_last) begin
            r_out_crc <= w_crc;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_crc_value = r_out_crc;

    `WFC_ASSERT_IMPL(a_stall_cause, i_clk, i_rst_n, o_in_stall, r_in_valid && r_in_last && r_out_valid && i_out_stall)
    `WFC_ASSERT_IMPL(a_no_stall_empty, i_clk, i_rst_n, !r_in_valid, !o_in_stall)
    `WFC_ASSERT_NEXT(a_emit, i_clk, i_rst_n, proc && r_in_last, o_out_valid && (o_crc_value == $past(w_crc)))
    `WFC_ASSERT_NEXT(a_state_init, i_clk, i_rst_n, proc && r_in_last, (r_state.crc == C_CRC_INIT) && (r_state.pos == 2'd0))

endmodule

`default_nettype wire

[tb/tb_word_fed_crc32_engine_unit.sv]
// Testbench for word_fed_crc32_engine_unit: random and directed images vs a CRC-32 predictor.
`timescale 1ns / 1ps

module tb_word_fed_crc32_engine_unit;
    import wfcrc_pkg::*;

    localparam int RESET_CYCLES = 7;
    localparam int TOTAL_REQS   = 950;
    localparam int QUIET_FROM   = 830;
    localparam int HOLD_CYCLES  = 60;
    localparam int DRAIN_CYCLES = 10;
    localparam int CYCLE_LIMIT  = 200000;

    logic        clk;
    logic        rst_n       = 1'b0;
    logic        in_valid    = 1'b0;
    logic [7:0]  data_byte   = 8'd0;
    logic        byte_valid  = 1'b0;
    logic        last        = 1'b0;
    logic        out_stall   = 1'b0;
    logic        in_stall;
    logic        out_valid;
    logic [31:0] crc_value;

    // predictor state
    logic [31:0] run_crc    = C_CRC_INIT;
    logic [23:0] held_bytes = '0;
    logic [1:0]  held_cnt   = '0;
    logic [31:0] expected_crcs[$];

    bit quiet        = 1'b0;
    bit hold_pending = 1'b0;
    int stall_left   = 0;
    int hold_left    = 0;
    int cycle_cnt    = 0;
    int err_cnt      = 0;
    int reqs_sent    = 0;
    int idle_sent    = 0;
    int bytes_sent   = 0;
    int empty_images = 0;
    int crcs_checked = 0;
    int in_stall_cnt = 0;

    word_fed_crc32_engine_unit DUT (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .o_in_stall   (in_stall),
        .i_data_byte  (data_byte),
        .i_byte_valid (byte_valid),
        .i_last       (last),
        .o_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .o_crc_value  (crc_value)
    );

    always begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic logic [31:0] crc_fold32(input logic [31:0] crc, input logic [31:0] word);
        logic [31:0] v;
        v = crc ^ word;
        for (int i = 0; i < C_WORD_BITS; i++) begin
            v = v[31] ? ((v << 1) ^ C_POLY) : (v << 1);
        end
        return v;
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        err_cnt++;
    endtask

    // Update the running CRC for one accepted request; queue the CRC on end of image.
    task automatic track_crc(input logic [7:0] d, input logic bv, input logic lst);
        logic [31:0] final_crc;
        logic [31:0] pad_word;
        if (bv) begin
            bytes_sent++;
            if (held_cnt == C_LAST_POS) begin
                run_crc    = crc_fold32(run_crc, {d, held_bytes});
                held_bytes = '0;
                held_cnt   = '0;
            end else begin
                held_bytes[int'(held_cnt) * 8 +: 8] = d;
                held_cnt = held_cnt + 2'd1;
            end
        end
        if (lst) begin
            final_crc = run_crc;
            if (held_cnt != 2'd0) begin
                pad_word = {C_PAD_BYTE, held_bytes};
                for (int k = 1; k < 3; k++) begin
                    if (k >= held_cnt) begin
                        pad_word[k * 8 +: 8] = C_PAD_BYTE;
                    end
                end
                final_crc = crc_fold32(run_crc, pad_word);
            end else if (run_crc == C_CRC_INIT) begin
                empty_images++;
            end
            expected_crcs = {expected_crcs, final_crc};
            run_crc    = C_CRC_INIT;
            held_bytes = '0;
            held_cnt   = '0;
        end
    endtask

    task automatic send_req(input logic [7:0] d, input logic bv, input logic lst);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        in_valid   <= 1'b1;
        data_byte  <= d;
        byte_valid <= bv;
        last       <= lst;
        @(posedge clk);
        while (in_stall) begin
            in_stall_cnt++;
            @(posedge clk);
        end
        if (bv || lst) begin
            reqs_sent++;
        end else begin
            idle_sent++;
        end
        track_crc(d, bv, lst);
    endtask

    task automatic send_image(input int len, input bit bare_end);
        for (int k = 0; k < len; k++) begin
            send_req(8'($urandom_range(0, 255)), 1'b1, (k == len - 1) && !bare_end);
        end
        if (bare_end || len == 0) begin
            send_req(8'($urandom_range(0, 255)), 1'b0, 1'b1);
        end
    endtask

    // Receiver: random stall bursts, plus one long hold-off on request.
    always @(posedge clk) begin
        if (hold_pending) begin
            hold_pending = 1'b0;
            hold_left    = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            out_stall <= 1'b1;
            hold_left--;
        end else if (stall_left > 0) begin
            out_stall <= 1'b1;
            stall_left--;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
            out_stall <= 1'b1;
            stall_left = $urandom_range(0, 6);
        end else begin
            out_stall <= 1'b0;
        end
    end

    always @(posedge clk) begin
        logic [31:0] want;
        if (rst_n && out_valid && !out_stall) begin
            if (expected_crcs.size() == 0) begin
                report_mismatch($sformatf("crc %08h with no image pending", crc_value));
            end else begin
                want = expected_crcs.pop_front();
                crcs_checked++;
                if (crc_value !== want) begin
                    report_mismatch($sformatf("crc_value %08h, want %08h", crc_value, want));
                end
            end
        end
    end

    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d crcs pending", cycle_cnt,
                     expected_crcs.size());
            $display("tb_word_fed_crc32_engine_unit failed");
            $finish;
        end
    end

    task automatic test_empty_images();
        send_req(8'h00, 1'b0, 1'b1);
        send_req(8'hFF, 1'b0, 1'b1);
    endtask

    task automatic test_short_images();
        send_req(8'h00, 1'b1, 1'b1);
        send_req(8'hFF, 1'b1, 1'b0);
        send_req(8'h00, 1'b1, 1'b1);
        send_req(8'hFF, 1'b1, 1'b0);
        send_req(8'hFF, 1'b1, 1'b0);
        send_req(8'hFF, 1'b1, 1'b1);
        send_image(5, 1'b0);
    endtask

    task automatic test_aligned_end();
        send_req(8'h01, 1'b1, 1'b0);
        send_req(8'h80, 1'b1, 1'b0);
        send_req(8'h5A, 1'b1, 1'b0);
        send_req(8'hA5, 1'b1, 1'b0);
        send_req(8'h3C, 1'b0, 1'b1);
    endtask

    task automatic test_idle_items();
        send_req(8'h12, 1'b1, 1'b0);
        send_req(8'hFF, 1'b0, 1'b0);
        send_req(8'h00, 1'b0, 1'b0);
        send_req(8'h34, 1'b1, 1'b1);
    endtask

    // Long receiver hold-off while short images keep arriving; input must stall.
    task automatic test_full_backpressure();
        hold_pending = 1'b1;
        for (int n = 0; n < 12; n++) begin
            send_image(int'($urandom_range(0, 2)), 1'($urandom_range(0, 1)));
        end
    endtask

    task automatic test_random_images();
        int r;
        int len;
        while (reqs_sent + idle_sent < TOTAL_REQS) begin
            if (reqs_sent + idle_sent >= QUIET_FROM) begin
                quiet = 1'b1;
            end
            r   = $urandom_range(0, 9);
            len = (r < 3) ? $urandom_range(0, 3) :
                  (r < 8) ? $urandom_range(4, 12) : $urandom_range(13, 40);
            for (int k = 0; k < len; k++) begin
                if ($urandom_range(0, 9) == 0) begin
                    send_req(8'($urandom_range(0, 255)), 1'b0, 1'b0);
                end
                send_req(8'($urandom_range(0, 255)), 1'b1, 1'b0);
            end
            if (len == 0 || $urandom_range(0, 2) == 0) begin
                send_req(8'($urandom_range(0, 255)), 1'b0, 1'b1);
            end else begin
                // end on a byte carrying last
                send_req(8'($urandom_range(0, 255)), 1'b1, 1'b1);
            end
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_images();
        test_short_images();
        test_aligned_end();
        test_idle_items();
        test_full_backpressure();
        test_random_images();
        in_valid <= 1'b0;
        while (expected_crcs.size() != 0) begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("checked %0d image crcs (%0d empty) over %0d bytes and %0d idle requests",
                 crcs_checked, empty_images, bytes_sent, idle_sent);
        $display("receiver held off %0d cycles once; sender saw %0d stalled cycles",
                 HOLD_CYCLES, in_stall_cnt);
        if (err_cnt == 0) begin
            $display("tb_word_fed_crc32_engine_unit passed");
        end else begin
            $display("tb_word_fed_crc32_engine_unit failed");
        end
        $finish;
    end

endmodule
